[src/moh3d_pkg.sv]
// Shared constants, types and a helper function of the orbit density histogram.
package moh3d_pkg;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] MAX_ITER_RESET = 11'd1024;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  localparam int POINT_THREE_Q24 = 5033165;
  localparam logic signed [MUL_W-1:0] HALF_Q24 = 33'sd8388608;
  localparam logic [63:0] ESCAPE_Q48 = 64'd10 << 48;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic done;
    logic escaped;
  } orbit_stat_t;

  // Saturate a wide signed value to a Q8.24 word.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[src/moh3d_if.sv]
// Valid/ready channel interfaces for sample items and result items.
interface moh3d_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] c_re;
  logic signed [31:0] c_im;
  logic signed [31:0] start_re;
  logic [17:0]        voxel_index;
  modport source (output valid, action, c_re, c_im, start_re, voxel_index, input ready);
  modport sink (input valid, action, c_re, c_im, start_re, voxel_index, output ready);
endinterface

interface moh3d_out_if;
  logic        valid;
  logic        ready;
  logic        escaped;
  logic [9:0]  orbit_length;
  logic [9:0]  voxels_added;
  logic [31:0] voxel_count;
  modport source (output valid, escaped, orbit_length, voxels_added, voxel_count, input ready);
  modport sink (input valid, escaped, orbit_length, voxels_added, voxel_count, output ready);
endinterface

[src/moh3d_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module moh3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/moh3d_orbit.sv]
// Orbit iteration unit: one shared multiplier and a bit-serial square root.
module moh3d_orbit #(
  parameter int GRID = 64,
  parameter int MAX_ITER = 1024,
  localparam int IW = $clog2(MAX_ITER),
  localparam int LW = ($clog2(MAX_ITER + 1) > 11) ? $clog2(MAX_ITER + 1) : 11,
  localparam int VW = $clog2(GRID * GRID * GRID)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [31:0]       c_re,
  input  logic signed [31:0]       c_im,
  input  logic signed [31:0]       start_re,
  input  logic [LW-1:0]            lim,
  output moh3d_pkg::orbit_stat_t   stat,
  output logic [IW-1:0]            n,
  output logic                     wr_en,
  output logic [IW-1:0]            wr_addr,
  output logic [VW:0]              wr_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_XX = 4'd1, S_YY = 4'd2, S_XY = 4'd3,
                         S_NEW = 4'd4, S_SQX = 4'd5, S_SQY = 4'd6, S_SUM = 4'd7,
                         S_CHK = 4'd8, S_SQRT = 4'd9, S_PX = 4'd10, S_PY = 4'd11,
                         S_PZ = 4'd12, S_WR = 4'd13;
  localparam logic signed [moh3d_pkg::MUL_W-1:0] KPROJ =
    33'(moh3d_pkg::POINT_THREE_Q24 * GRID);
  localparam logic signed [18:0] GRID_S = 19'(GRID);
  localparam logic signed [18:0] ZERO_S = 19'sd0;
  localparam int PW = moh3d_pkg::PROD_W;

  logic [3:0] state;
  logic signed [31:0] x, y, cre, cim, ox, oy, nx, ny;
  logic signed [PW-1:0] p, xx, yy;
  logic [63:0] sqold, sqx, sqnew, rad;
  logic neg;
  logic [35:0] rem;
  logic [31:0] root;
  logic [4:0] cnt;
  logic signed [18:0] ix, iy;
  logic [IW-1:0] i;

  logic signed [moh3d_pkg::MUL_W-1:0] opa, opb, ux;
  logic signed [PW-1:0] dsq, sum_re, sum_im;
  logic [35:0] rem_t, trial;
  logic signed [18:0] iz;
  logic in_grid, is_cycle, is_last;
  logic [VW-1:0] vox;

  assign ux = {nx[31], nx} + moh3d_pkg::HALF_Q24;

  always_comb begin
    opa = {x[31], x};
    opb = {x[31], x};
    unique case (state)
      S_YY: begin
        opa = {y[31], y};
        opb = {y[31], y};
      end
      S_XY: opb = {y[31], y};
      S_SQX: begin
        opa = {nx[31], nx};
        opb = {nx[31], nx};
      end
      S_SQY: begin
        opa = {ny[31], ny};
        opb = {ny[31], ny};
      end
      S_PX: begin
        opa = ux;
        opb = KPROJ;
      end
      S_PY: begin
        opa = {ny[31], ny};
        opb = KPROJ;
      end
      S_PZ: begin
        opa = {1'b0, root};
        opb = KPROJ;
      end
      default: ;
    endcase
  end

  assign dsq    = xx - yy;
  assign sum_re = (dsq >>> 24) + 66'(cre);
  assign sum_im = (p >>> 23) + 66'(cim);

  assign rem_t = {rem[33:0], rad[63:62]};
  assign trial = {2'b00, root, 2'b01};

  assign iz = 19'($signed(p[PW-1:48]));
  assign in_grid = !neg && ix >= ZERO_S && ix < GRID_S && iy >= ZERO_S && iy < GRID_S &&
                   iz >= ZERO_S && iz < GRID_S;
  assign vox = (VW'(ix[8:0]) + VW'(iz[8:0]) * VW'(GRID)) * VW'(GRID) + VW'(iy[8:0]);
  assign is_cycle = (ox == nx) && (oy == ny);
  assign is_last  = (LW'(i) + LW'(1)) == lim;

  assign wr_en   = (state == S_WR);
  assign wr_addr = i;
  assign wr_data = {in_grid, vox};

  always_ff @(posedge clk) begin
    p <= opa * opb;
    if (rst) begin
      state       <= S_IDLE;
      stat        <= '0;
      n           <= '0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cre <= c_re >>> 4;
            cim <= c_im >>> 4;
            x   <= start_re >>> 4;
            y   <= '0;
            i   <= '0;
            if (lim == '0) begin
              stat <= '{done: 1'b1, escaped: 1'b0};
              n    <= '0;
            end else begin
              state <= S_XX;
            end
          end
        end
        S_XX: begin
          // Snapshot at step zero and at every power-of-two step.
          if ((i & (i - IW'(1))) == '0) begin
            ox <= x;
            oy <= y;
          end
          state <= S_YY;
        end
        S_YY: begin
          xx    <= p;
          state <= S_XY;
        end
        S_XY: begin
          yy    <= p;
          state <= S_NEW;
        end
        S_NEW: begin
          nx    <= moh3d_pkg::sat32(sum_re);
          ny    <= moh3d_pkg::sat32(sum_im);
          sqold <= xx[63:0] + yy[63:0];
          state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sqx   <= p[63:0];
          state <= S_SUM;
        end
        S_SUM: begin
          sqnew <= sqx + p[63:0];
          state <= S_CHK;
        end
        S_CHK: begin
          rad   <= sqnew - sqold;
          neg   <= sqnew < sqold;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rad <= {rad[61:0], 2'b00};
          if (rem_t >= trial) begin
            rem  <= rem_t - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_t;
            root <= {root[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(moh3d_pkg::SQRT_STEPS - 1)) begin
            state <= S_PX;
          end
        end
        S_PX: state <= S_PY;
        S_PY: begin
          ix    <= 19'($signed(p[PW-1:48])) + 19'(GRID / 2);
          state <= S_PZ;
        end
        S_PZ: begin
          iy    <= 19'($signed(p[PW-1:48])) + 19'(GRID / 2);
          state <= S_WR;
        end
        S_WR: begin
          priority if (is_cycle) begin
            stat  <= '{done: 1'b1, escaped: 1'b0};
            n     <= i;
            state <= S_IDLE;
          end else if (sqnew > moh3d_pkg::ESCAPE_Q48) begin
            stat  <= '{done: 1'b1, escaped: 1'b1};
            n     <= i;
            state <= S_IDLE;
          end else if (is_last) begin
            stat  <= '{done: 1'b1, escaped: 1'b0};
            n     <= i;
            state <= S_IDLE;
          end else begin
            x     <= nx;
            y     <= ny;
            i     <= i + IW'(1);
            state <= S_XX;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/mandelbrot_orbit_histogram_3d_core.sv]
// Top level of the 3D orbit density histogram core.
//
// Items arrive on in_ch (valid/ready); one transfer carries an action, the
// sample point c_re, c_im, start_re (signed Q4.28) and a voxel_index. Action 0
// iterates z = z*z + c, stores the voxel of every orbit point and, when the
// orbit escapes late enough, increments those histogram counters. Action 1 reads one
// counter. Each item gives exactly one result transfer on out_ch. The user must write
// max_iterations through cfg_we / cfg_data only while idle; the core does not check.
//
// An action 1 read passes through T_RDA and T_FIN. Action 0 runs each orbit step
// through the shared-multiplier and control states and the square-root steps of
// moh3d_orbit, then reads each kept point in T_HA and T_HB, counts a valid one in
// T_HC and finishes in T_FIN. The single multiplier and the one-bit-per-cycle square
// root set the pace; one item is in work at a time, in_ch.ready high only while idle.
//
// Reset: the counter memory is cleared by a pass over all GRID^3 counters (262144 at
// the default size), one counter per cycle, while in_ch.ready stays low.
// max_iterations returns to 1024. When out_ch stalls, the result waits in the
// output register and the next item can still be accepted; its own result is
// held back until the register is free.
module mandelbrot_orbit_histogram_3d_core #(
  parameter int GRID = 64,
  parameter int MAX_ITER = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  moh3d_in_if.sink                        in_ch,
  moh3d_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [moh3d_pkg::CFG_W-1:0]     cfg_data
);
  localparam int IW = $clog2(MAX_ITER);
  localparam int LW = ($clog2(MAX_ITER + 1) > 11) ? $clog2(MAX_ITER + 1) : 11;
  localparam int VOXELS = GRID * GRID * GRID;
  localparam int VW = $clog2(VOXELS);

  localparam logic [3:0] T_CLR = 4'd0, T_IDLE = 4'd1, T_ORB = 4'd2, T_HA = 4'd3,
                         T_HB = 4'd4, T_HC = 4'd5, T_RDA = 4'd6, T_FIN = 4'd7;

  logic [3:0] state;
  logic [moh3d_pkg::CFG_W-1:0] max_iterations;
  logic [LW-1:0] lim;
  logic [VW-1:0] clr_addr;
  logic [IW-1:0] j, n_keep, added;
  logic [VW-1:0] vidx;
  logic rd_in_range;
  logic r_escaped;
  logic [31:0] r_count;

  logic start;
  moh3d_pkg::orbit_stat_t stat;
  logic [IW-1:0] orb_n;
  logic orb_we;
  logic [IW-1:0] orb_waddr;
  logic [VW:0] orb_wdata, orb_rdata;

  logic cnt_we;
  logic [VW-1:0] cnt_waddr, cnt_raddr;
  logic [31:0] cnt_wdata, cnt_rdata;

  logic accept, out_free, keep_orbit;

  // The effective limit is the register clipped to the orbit store depth.
  assign lim = (LW'(max_iterations) > LW'(MAX_ITER)) ? LW'(MAX_ITER) : LW'(max_iterations);

  assign in_ch.ready = (state == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept && (in_ch.action == moh3d_pkg::ACT_SAMPLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign keep_orbit  = stat.escaped && (LW'(orb_n) >= (lim >> 5)) && (orb_n != '0);

  moh3d_orbit #(.GRID(GRID), .MAX_ITER(MAX_ITER)) u_orbit (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .c_re     (in_ch.c_re),
    .c_im     (in_ch.c_im),
    .start_re (in_ch.start_re),
    .lim      (lim),
    .stat     (stat),
    .n        (orb_n),
    .wr_en    (orb_we),
    .wr_addr  (orb_waddr),
    .wr_data  (orb_wdata)
  );

  moh3d_ram #(.WIDTH(VW + 1), .DEPTH(MAX_ITER)) u_orbit_ram (
    .clk   (clk),
    .we    (orb_we),
    .waddr (orb_waddr),
    .wdata (orb_wdata),
    .raddr (j),
    .rdata (orb_rdata)
  );

  moh3d_ram #(.WIDTH(32), .DEPTH(VOXELS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Counter memory ports: the clearing pass and the increment share the write port.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    cnt_raddr = VW'(in_ch.voxel_index);
    if (state == T_CLR) begin
      cnt_we = 1'b1;
    end else if (state == T_HC) begin
      cnt_we    = (cnt_rdata != '1);
      cnt_waddr = vidx;
      cnt_wdata = cnt_rdata + 32'd1;
    end else if (state == T_HB) begin
      cnt_raddr = orb_rdata[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_CLR;
      clr_addr       <= '0;
      max_iterations <= moh3d_pkg::MAX_ITER_RESET;
      out_ch.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_iterations <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        T_CLR: begin
          clr_addr <= clr_addr + VW'(1);
          if (clr_addr == VW'(VOXELS - 1)) begin
            state <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept) begin
            r_escaped <= 1'b0;
            n_keep    <= '0;
            added     <= '0;
            r_count   <= '0;
            j         <= '0;
            if (in_ch.action == moh3d_pkg::ACT_READ) begin
              rd_in_range <= 25'(in_ch.voxel_index) < 25'(VOXELS);
              state       <= T_RDA;
            end else begin
              state <= T_ORB;
            end
          end
        end
        T_RDA: begin
          r_count <= rd_in_range ? cnt_rdata : '0;
          state   <= T_FIN;
        end
        T_ORB: begin
          if (stat.done) begin
            r_escaped <= stat.escaped;
            n_keep    <= orb_n;
            state     <= keep_orbit ? T_HA : T_FIN;
          end
        end
        T_HA: state <= T_HB;
        T_HB: begin
          // Entries marked invalid had a negative radicand or left the grid.
          vidx <= orb_rdata[VW-1:0];
          if (orb_rdata[VW]) begin
            state <= T_HC;
          end else begin
            j     <= j + IW'(1);
            state <= ((j + IW'(1)) == n_keep) ? T_FIN : T_HA;
          end
        end
        T_HC: begin
          if (cnt_rdata != '1) begin
            added <= added + IW'(1);
          end
          j     <= j + IW'(1);
          state <= ((j + IW'(1)) == n_keep) ? T_FIN : T_HA;
        end
        T_FIN: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.escaped      <= r_escaped;
            out_ch.orbit_length <= 10'(n_keep);
            out_ch.voxels_added <= 10'(added);
            out_ch.voxel_count  <= r_count;
            state               <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule

[src/moh3d_checker.sv]
// Port-level checker for the orbit density histogram core, bound to the top level.
module moh3d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        escaped,
  input logic [9:0]  orbit_length,
  input logic [9:0]  voxels_added,
  input logic [31:0] voxel_count
);
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after a transfer");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && voxel_count != 32'd0 |->
      !escaped && orbit_length == 10'd0 && voxels_added == 10'd0)
    else $error("read result carries sample fields");

  a_no_add_unescaped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !escaped |-> voxels_added == 10'd0)
    else $error("counters added for an orbit that did not escape");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(voxel_count))
    else $error("stalled result changed");
endmodule

bind mandelbrot_orbit_histogram_3d_core moh3d_checker u_moh3d_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .escaped      (out_ch.escaped),
  .orbit_length (out_ch.orbit_length),
  .voxels_added (out_ch.voxels_added),
  .voxel_count  (out_ch.voxel_count)
);

[bench/testbench.sv]
// Self-checking testbench for the 3D orbit density histogram core.
`timescale 1ns / 1ps

module testbench;

  localparam int GRID_SIZE = 64;
  localparam int ITER_CAP = 1024;
  localparam int VOXEL_TOTAL = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int unsigned SLOT_VALID = 32'h8000_0000;
  localparam longint FRAC_THREE_TENTHS = 5033165;
  localparam longint FRAC_HALF = 8388608;
  localparam int IDLE_PCT = 25;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic               action;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic signed [31:0] start_re;
    logic [17:0]        voxel_index;
  } sample_t;

  typedef struct {
    logic        escaped;
    logic [9:0]  orbit_length;
    logic [9:0]  voxels_added;
    logic [31:0] voxel_count;
  } outcome_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [moh3d_pkg::CFG_W-1:0] cfg_data;

  moh3d_in_if  in_ch ();
  moh3d_out_if out_ch ();

  mandelbrot_orbit_histogram_3d_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // The predictor's own copy of the block state.
  int unsigned density[VOXEL_TOTAL];
  int unsigned orbit_slots[ITER_CAP];
  logic [moh3d_pkg::CFG_W-1:0] iter_limit_reg;
  int unsigned hit_voxels[$];

  outcome_t pending_outcomes[$];
  int mismatch_count;
  bit sender_quiet;
  bit receiver_quiet;
  bit hold_request;
  int hold_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint clamp_q824(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic bit [63:0] square_mag(longint v);
    bit [63:0] m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint grid_coord(longint u);
    return (u * FRAC_THREE_TENTHS * GRID_SIZE) >>> 48;
  endfunction

  // Voxel of one orbit point, with the valid flag in bit 31; zero when skipped.
  function automatic int unsigned orbit_point_voxel(longint nx, longint ny,
                                                    bit [63:0] sq_new, bit [63:0] sq_old);
    longint ix;
    longint iy;
    longint iz;
    if (sq_new < sq_old) begin
      return 0;
    end
    ix = grid_coord(nx + FRAC_HALF) + GRID_SIZE / 2;
    iy = grid_coord(ny) + GRID_SIZE / 2;
    iz = grid_coord(longint'(int_sqrt(sq_new - sq_old)));
    if (ix < 0 || iy < 0 || iz < 0 || ix >= GRID_SIZE || iy >= GRID_SIZE || iz >= GRID_SIZE) begin
      return 0;
    end
    return SLOT_VALID | int'((ix + iz * GRID_SIZE) * GRID_SIZE + iy);
  endfunction

  // Expected result of an item; a sample is iterated and updates the histogram copy.
  function automatic outcome_t trace_orbit(sample_t s);
    outcome_t r;
    longint cre, cim, x, y, ox, oy, nx, ny;
    bit [63:0] sq_new, sq_old;
    int lim, n, added;
    int unsigned slot;
    bit esc;
    r = '{default: '0};
    if (s.action == moh3d_pkg::ACT_READ) begin
      if (s.voxel_index < VOXEL_TOTAL) begin
        r.voxel_count = density[s.voxel_index];
      end
      return r;
    end
    cre = longint'(s.c_re) >>> 4;
    cim = longint'(s.c_im) >>> 4;
    x = longint'(s.start_re) >>> 4;
    y = 0;
    ox = 0;
    oy = 0;
    n = 0;
    added = 0;
    esc = 1'b0;
    lim = (iter_limit_reg > ITER_CAP) ? ITER_CAP : int'(iter_limit_reg);
    for (int i = 0; i < lim; i++) begin
      if ((i & (i - 1)) == 0) begin
        ox = x;
        oy = y;
      end
      nx = clamp_q824(((x * x - y * y) >>> 24) + cre);
      ny = clamp_q824(((x * y) >>> 23) + cim);
      sq_new = square_mag(nx) + square_mag(ny);
      sq_old = square_mag(x) + square_mag(y);
      orbit_slots[i] = orbit_point_voxel(nx, ny, sq_new, sq_old);
      n = i;
      // The cycle check wins over the escape check.
      if (ox == nx && oy == ny) begin
        break;
      end
      if (sq_new > moh3d_pkg::ESCAPE_Q48) begin
        esc = 1'b1;
        break;
      end
      x = nx;
      y = ny;
    end
    if (esc && n >= (lim >> 5)) begin
      for (int i = 0; i < n; i++) begin
        slot = orbit_slots[i];
        if ((slot & SLOT_VALID) != 0) begin
          slot = slot & ~SLOT_VALID;
          if (slot < VOXEL_TOTAL && density[slot] != 32'hFFFF_FFFF) begin
            density[slot]++;
            added++;
            if (hit_voxels.size() < 512) begin
              hit_voxels.push_back(slot);
            end
          end
        end
      end
    end
    r.escaped = esc;
    r.orbit_length = n[9:0];
    r.voxels_added = added[9:0];
    return r;
  endfunction

  // Offers one item, with a random gap in front, and records its expectation
  // at the transfer.
  task automatic send_item(sample_t s);
    int gap;
    gap = 0;
    if (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= s.action;
    in_ch.c_re <= s.c_re;
    in_ch.c_im <= s.c_im;
    in_ch.start_re <= s.start_re;
    in_ch.voxel_index <= s.voxel_index;
    do @(posedge clk); while (!in_ch.ready);
    pending_outcomes.push_back(trace_orbit(s));
  endtask

  task automatic send_sample(logic signed [31:0] cre, logic signed [31:0] cim,
                             logic signed [31:0] sre);
    sample_t s;
    s.action = moh3d_pkg::ACT_SAMPLE;
    s.c_re = cre;
    s.c_im = cim;
    s.start_re = sre;
    s.voxel_index = 18'($urandom);
    send_item(s);
  endtask

  task automatic send_read(logic [17:0] idx);
    sample_t s;
    s.action = moh3d_pkg::ACT_READ;
    s.c_re = $urandom;
    s.c_im = $urandom;
    s.start_re = $urandom;
    s.voxel_index = idx;
    send_item(s);
  endtask

  // Writes the iteration limit once every outstanding result has come back.
  task automatic set_iter_limit(logic [moh3d_pkg::CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    iter_limit_reg = value;
  endtask

  // Random point near the set boundary, with a small real start.
  task automatic send_boundary_sample();
    send_sample($urandom_range(0, 671088640) - 536870912,
                $urandom_range(0, 644245094) - 322122547,
                $urandom_range(0, 268435456) - 134217728);
  endtask

  // Result checker: compares each transfer on out_ch with the oldest expectation.
  // The receiver's ready is then chosen for the next edge.
  always @(posedge clk) begin
    outcome_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: unexpected result transfer at %0t", $realtime);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.escaped !== want.escaped || out_ch.orbit_length !== want.orbit_length ||
            out_ch.voxels_added !== want.voxels_added ||
            out_ch.voxel_count !== want.voxel_count) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: escaped %0d/%0d length %0d/%0d added %0d/%0d count %0d/%0d",
                     want.escaped, out_ch.escaped, want.orbit_length, out_ch.orbit_length,
                     want.voxels_added, out_ch.voxels_added,
                     want.voxel_count, out_ch.voxel_count);
          end
        end
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 20000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= receiver_quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Counters start cleared: read both ends of the histogram and a random counter.
  task automatic test_reads_after_reset();
    send_read('0);
    send_read(18'h3FFFF);
    send_read(18'($urandom));
  endtask

  // Field extremes, the trivial fixed point and the saturating cases.
  task automatic test_field_extremes();
    send_sample(0, 0, 0);
    send_sample(32'sh7FFFFFFF, 0, 0);
    send_sample(32'sh80000000, 0, 0);
    send_sample(0, 32'sh7FFFFFFF, 0);
    send_sample(0, 32'sh80000000, 0);
    send_sample(0, 0, 32'sh7FFFFFFF);
    send_sample(0, 0, 32'sh80000000);
    send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000);
    // Late escapes near the boundary: kept orbits with some points off the grid.
    send_sample(-32'sd201326592, 32'sd26843546, 0);
    send_sample(32'sd73819750, 32'sd5368709, 32'sd26843546);
  endtask

  // Limit zero, a limit above the cap, and a short limit of 32.
  task automatic test_iteration_limits();
    set_iter_limit('0);
    send_sample(0, 0, 0);
    send_sample(32'sh7FFFFFFF, 0, 0);
    set_iter_limit(11'h7FF);
    send_sample(-32'sd201326592, 32'sd26843546, 0);
    send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    set_iter_limit(11'd32);
    // A very short escape still reaches the kept minimum at this limit.
    send_sample(32'sd536870912, 0, 0);
    send_sample(-32'sd201326592, 32'sd26843546, 0);
    send_sample(32'sd73819750, 32'sd5368709, 32'sd26843546);
  endtask

  // Mostly boundary samples with a few full-range ones and readbacks of hit voxels.
  task automatic test_random_mix();
    int r;
    for (int phase = 0; phase < 4; phase++) begin
      set_iter_limit(11'($urandom_range(32, 128)));
      sender_quiet = (phase == 1);
      receiver_quiet = (phase == 1);
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(99);
        if (r < 65) begin
          send_boundary_sample();
        end else if (r < 75) begin
          send_sample($urandom, $urandom, $urandom);
        end else if (r < 90 && hit_voxels.size() != 0) begin
          send_read(18'(hit_voxels[$urandom_range(hit_voxels.size() - 1)]));
        end else begin
          send_read(18'($urandom));
        end
      end
    end
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    set_iter_limit(11'd32);
    hold_request = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) begin
        send_boundary_sample();
      end else if (hit_voxels.size() != 0) begin
        send_read(18'(hit_voxels[$urandom_range(hit_voxels.size() - 1)]));
      end else begin
        send_read(18'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = moh3d_pkg::ACT_SAMPLE;
    in_ch.c_re = '0;
    in_ch.c_im = '0;
    in_ch.start_re = '0;
    in_ch.voxel_index = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    iter_limit_reg = moh3d_pkg::MAX_ITER_RESET;
    foreach (density[i]) begin
      density[i] = 0;
    end
    foreach (orbit_slots[i]) begin
      orbit_slots[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The core clears its counter memory after reset; send_item waits on ready.
    test_reads_after_reset();
    test_field_extremes();
    test_iteration_limits();
    test_random_mix();
    test_output_stall();
    set_iter_limit(11'd1024);
    send_sample(-32'sd201326592, 32'sd26843546, 0);
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the clearing pass.
  initial begin
    #1_000_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
